FILE: hw/rtl/line_position_estimator_assert.svh
// ---------------------------------------------------------------------------
// Line position estimator assertion macros
// Property wrappers for the estimator, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef LINE_POSITION_ESTIMATOR_ASSERT_SVH
`define LINE_POSITION_ESTIMATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line position estimator: property failed");

// next-cycle implication
`define LPE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line position estimator: property failed");

`else

`define LPE_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/lpe_pkg.sv
// ---------------------------------------------------------------------------
// Line position estimator package
// Widths, register indexes, reset values and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF   = 14;

   localparam int REG_W     = 12;    // calibration registers and divisor
   localparam int LVL_W     = 10;    // intersection level
   localparam int MAP_BITS  = 10;    // mapped sample 0..1000
   localparam int SCALE_MAX = 1000;
   localparam int ERR_W     = 16;
   localparam int FLAG_W    = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WHITE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERSECT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TOTAL = 3'd4;

   localparam logic [REG_W-1:0] WHITE_RST     = 12'd200;
   localparam logic [REG_W-1:0] BLACK_RST     = 12'd3000;
   localparam logic [REG_W-1:0] START_RST     = 12'd500;
   localparam logic [LVL_W-1:0] INTERSECT_RST = 10'd600;
   localparam logic [REG_W-1:0] MIN_TOTAL_RST = 12'd100;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_DIV,
      S_DECIDE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/line_position_estimator.sv
// Flow: a new request is taken only in the idle state, once the last result
//    has gone into the response register; one shared restoring divider
//    (one quotient bit a cycle) does the three mappings and the centroid.
// Reset: synchronous, active high; registers return to calibration defaults
//    and the stored error to zero.
// ---------------------------------------------------------------------------
// Line position estimator
// Maps three reflectance samples to 0..1000 and forms the weighted centroid
// of the line, with intersection, lost-line and start-mark detection.
// ---------------------------------------------------------------------------
`default_nettype none
`include "line_position_estimator_assert.svh"

module line_position_estimator
   import lpe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int REQ_W       = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request: left_raw, center_raw, right_raw
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,
   // response: line_error
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [ERR_W-1:0]          rsp_tdata,
   // response flags: line_seen, at_intersection, start_mark
   output logic [FLAG_W-1:0]         rsp_tuser,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   localparam int VW     = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
   localparam int QW     = (FRAC_BITS + 1 > MAP_BITS) ? FRAC_BITS + 1 : MAP_BITS;
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int NUM_W  = REG_W + MAP_BITS;
   localparam int ONE_I  = 1 << FRAC_BITS;
   localparam int TEN_I  = ONE_I / 10;
   localparam int POS_I  = (ONE_I > 32767) ? 32767 : ONE_I;
   localparam logic signed [ERR_W-1:0] ERR_POS  = ERR_W'(POS_I);
   localparam logic signed [ERR_W-1:0] ERR_NEG  = ERR_W'(-ONE_I);
   localparam logic signed [ERR_W-1:0] TENTH_P  = ERR_W'(TEN_I);
   localparam logic signed [ERR_W-1:0] TENTH_N  = ERR_W'(-TEN_I);
   localparam logic [1:0]              LAST_IDX = 2'd2;

   state_type                 state_ff, state_in;

   logic [REG_W-1:0]          white_ff, black_ff, start_thr_ff, min_total_ff;
   logic [LVL_W-1:0]          inter_lvl_ff;

   logic [SAMPLE_BITS-1:0]    raw_ff [3];
   logic [SAMPLE_BITS-1:0]    raw_in [3];
   logic                      start_ff, start_in;
   logic [1:0]                idx_ff, idx_in;
   logic [MAP_BITS-1:0]       map_ff [3];
   logic [MAP_BITS-1:0]       map_in [3];

   logic [REG_W-1:0]          rem_ff, rem_in;
   logic [QW-1:0]             quo_ff, quo_in;
   logic [REG_W-1:0]          dvs_ff, dvs_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      cent_ff, cent_in;
   logic                      neg_ff, neg_in;

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      seen_ff, seen_in;
   logic                      inter_ff, inter_in;
   logic signed [ERR_W-1:0]   last_good_ff, last_good_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ERR_W-1:0]          rsp_err_ff, rsp_err_in;
   logic [FLAG_W-1:0]         rsp_flags_ff, rsp_flags_in;

   // combinational helpers
   logic                      req_accept;
   logic [SAMPLE_BITS-1:0]    fld_l, fld_c, fld_r;
   logic [VW-1:0]             thr_ext, v_ext, white_ext, black_ext, clamp_v;
   logic [REG_W-1:0]          map_off, den;
   logic [NUM_W-1:0]          map_num;
   logic                      window_empty;
   logic [REG_W:0]            part;
   logic                      ge;
   logic [REG_W:0]            part_diff;
   logic [REG_W-1:0]          rem_step;
   logic [QW-1:0]             quo_step;
   logic [REG_W-1:0]          sum;
   logic                      diff_neg;
   logic [MAP_BITS-1:0]       diff_mag;
   logic [FRAC_BITS:0]        cent_low;
   logic [ERR_W:0]            mag_ext, sval;

   assign fld_l = req_tdata[SAMPLE_BITS-1:0];
   assign fld_c = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign fld_r = req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_err_ff;
   assign rsp_tuser  = rsp_flags_ff;

   // mapping front end
   assign thr_ext      = VW'(start_thr_ff);
   assign white_ext    = VW'(white_ff);
   assign black_ext    = VW'(black_ff);
   assign v_ext        = VW'(raw_ff[idx_ff]);
   assign window_empty = (black_ff <= white_ff);
   assign den          = black_ff - white_ff;

   always_comb begin
      if (v_ext < white_ext) begin
         clamp_v = white_ext;
      end else if (v_ext > black_ext) begin
         clamp_v = black_ext;
      end else begin
         clamp_v = v_ext;
      end
   end

   assign map_off = REG_W'(clamp_v - white_ext);
   assign map_num = NUM_W'(map_off) * NUM_W'(SCALE_MAX);

   // shared divider step
   assign part      = {rem_ff, quo_ff[QW-1]};
   assign ge        = (part >= {1'b0, dvs_ff});
   assign part_diff = part - {1'b0, dvs_ff};
   assign rem_step  = ge ? part_diff[REG_W-1:0] : part[REG_W-1:0];
   assign quo_step  = {quo_ff[QW-2:0], ge};

   // centroid set-up
   assign sum      = REG_W'(map_ff[0]) + REG_W'(map_ff[1]) + REG_W'(map_ff[2]);
   assign diff_neg = (map_ff[2] < map_ff[0]);
   assign diff_mag = diff_neg ? (map_ff[0] - map_ff[2]) : (map_ff[2] - map_ff[0]);
   assign cent_low = {diff_mag[0], {FRAC_BITS{1'b0}}};

   assign mag_ext = (ERR_W + 1)'(quo_step[FRAC_BITS:0]);
   assign sval    = neg_ff ? ((ERR_W + 1)'(0) - mag_ext) : mag_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         white_ff     <= WHITE_RST;
         black_ff     <= BLACK_RST;
         start_thr_ff <= START_RST;
         inter_lvl_ff <= INTERSECT_RST;
         min_total_ff <= MIN_TOTAL_RST;
         last_good_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_good_ff <= last_good_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WHITE:     white_ff     <= csr_wdata;
               CSR_BLACK:     black_ff     <= csr_wdata;
               CSR_START:     start_thr_ff <= csr_wdata;
               CSR_INTERSECT: inter_lvl_ff <= csr_wdata[LVL_W-1:0];
               CSR_MIN_TOTAL: min_total_ff <= csr_wdata;
               default:       ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      start_ff     <= start_in;
      idx_ff       <= idx_in;
      map_ff       <= map_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      cent_ff      <= cent_in;
      neg_ff       <= neg_in;
      err_ff       <= err_in;
      seen_ff      <= seen_in;
      inter_ff     <= inter_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      start_in     = start_ff;
      idx_in       = idx_ff;
      map_in       = map_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      cent_in      = cent_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      seen_in      = seen_ff;
      inter_in     = inter_ff;
      last_good_in = last_good_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               raw_in[0] = fld_l;
               raw_in[1] = fld_c;
               raw_in[2] = fld_r;
               start_in  = (VW'(fld_l) > thr_ext) || (VW'(fld_c) > thr_ext) ||
                           (VW'(fld_r) > thr_ext);
               idx_in    = '0;
               cent_in   = 1'b0;
               state_in  = S_MAP;
            end
         end

         S_MAP: begin
            if (window_empty) begin
               map_in[idx_ff] = '0;
               idx_in         = idx_ff + 2'd1;
               state_in       = (idx_ff == LAST_IDX) ? S_DECIDE : S_MAP;
            end else begin
               // quotient fits in MAP_BITS, so the top of the dividend is preloaded
               rem_in   = map_num[NUM_W-1:MAP_BITS];
               quo_in   = QW'(map_num[MAP_BITS-1:0]) << (QW - MAP_BITS);
               dvs_in   = den;
               cnt_in   = CNT_W'(MAP_BITS);
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               if (cent_ff) begin
                  if (!neg_ff && (mag_ext > (ERR_W + 1)'(32767))) begin
                     err_in = ERR_W'(32767);
                  end else begin
                     err_in = sval[ERR_W-1:0];
                  end
                  seen_in  = 1'b1;
                  inter_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  map_in[idx_ff] = quo_step[MAP_BITS-1:0];
                  idx_in         = idx_ff + 2'd1;
                  state_in       = (idx_ff == LAST_IDX) ? S_DECIDE : S_MAP;
               end
            end
         end

         S_DECIDE: begin
            if ((map_ff[0] > inter_lvl_ff) && (map_ff[2] > inter_lvl_ff)) begin
               err_in   = '0;
               seen_in  = 1'b1;
               inter_in = 1'b1;
               state_in = S_DONE;
            end else if (sum > min_total_ff) begin
               rem_in   = REG_W'(diff_mag[MAP_BITS-1:1]);
               quo_in   = QW'(cent_low) << (QW - FRAC_BITS - 1);
               dvs_in   = sum;
               cnt_in   = CNT_W'(FRAC_BITS + 1);
               neg_in   = diff_neg;
               cent_in  = 1'b1;
               state_in = S_DIV;
            end else begin
               // line lost: steer from the sign of the last good error, zero within +/- one tenth
               if (last_good_ff > TENTH_P) begin
                  err_in = ERR_POS;
               end else if (last_good_ff < TENTH_N) begin
                  err_in = ERR_NEG;
               end else begin
                  err_in = '0;
               end
               seen_in  = 1'b0;
               inter_in = 1'b0;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_flags_in = {start_ff, inter_ff, seen_ff};
               if (cent_ff) begin
                  last_good_in = err_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `LPE_ASSERT_NXT(a_busy_after_request, clock, reset,
      req_tvalid && req_tready, !req_tready)
   `LPE_ASSERT_IMP(a_div_rem_bound, clock, reset, state_ff == S_DIV, rem_ff < dvs_ff)
   `LPE_ASSERT_IMP(a_map_range, clock, reset,
      (state_ff == S_DIV) && !cent_ff && (cnt_ff == CNT_W'(1)),
      quo_step[MAP_BITS-1:0] <= MAP_BITS'(SCALE_MAX))
   `LPE_ASSERT_IMP(a_inter_implies_seen, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   `LPE_ASSERT_NXT(a_hold_when_stalled, clock, reset,
      (state_ff == S_DONE) && rsp_tvalid && !rsp_tready, state_ff == S_DONE)

endmodule

`default_nettype wire
